// File: sv/trt_pkg.sv
// ----------------------------------------------------------------------------
// trt_pkg
// Shared constants for the thermistor ratio to temperature converter:
// the descending NTC resistance table and default configuration values.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int TABLE_LEN         = 111;
  localparam int TAB_IDX_W         = 7;
  localparam int TABLE_DEPTH_DEF   = 111;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int CAPTURE_W         = 16;
  localparam int OHMS_W            = 16;
  localparam int TEMP_W            = 8;
  localparam int TEMP_OFFSET       = 10;
  localparam logic [OHMS_W-1:0] OHMS_RESET = 16'd1000;
  localparam logic [OHMS_W-1:0] RES_MAX    = 16'hFFFF;

  // Entry i belongs to i - TEMP_OFFSET degrees C.
  localparam logic [15:0] RES_TABLE [0:TABLE_LEN-1] = '{
    16'd5258, 16'd4984, 16'd4726, 16'd4484, 16'd4255, 16'd4040, 16'd3837, 16'd3645,
    16'd3465, 16'd3295, 16'd3134, 16'd2982, 16'd2838, 16'd2703, 16'd2574, 16'd2453,
    16'd2338, 16'd2230, 16'd2127, 16'd2029, 16'd1937, 16'd1849, 16'd1766, 16'd1688,
    16'd1613, 16'd1542, 16'd1475, 16'd1411, 16'd1350, 16'd1292, 16'd1237, 16'd1185,
    16'd1135, 16'd1088, 16'd1043, 16'd1000, 16'd959,  16'd920,  16'd883,  16'd848,
    16'd814,  16'd782,  16'd751,  16'd722,  16'd694,  16'd667,  16'd641,  16'd617,
    16'd594,  16'd571,  16'd550,  16'd530,  16'd510,  16'd491,  16'd473,  16'd456,
    16'd440,  16'd424,  16'd409,  16'd395,  16'd381,  16'd367,  16'd355,  16'd342,
    16'd331,  16'd319,  16'd309,  16'd298,  16'd288,  16'd279,  16'd269,  16'd261,
    16'd252,  16'd244,  16'd236,  16'd228,  16'd221,  16'd214,  16'd207,  16'd201,
    16'd195,  16'd189,  16'd183,  16'd177,  16'd172,  16'd166,  16'd161,  16'd157,
    16'd152,  16'd147,  16'd143,  16'd139,  16'd135,  16'd131,  16'd127,  16'd124,
    16'd120,  16'd117,  16'd113,  16'd110,  16'd107,  16'd104,  16'd101,  16'd98,
    16'd96,   16'd93,   16'd91,   16'd88,   16'd86,   16'd84,   16'd81
  };

endpackage

// File: sv/thermistor_ratio_to_temperature_top.sv
// ----------------------------------------------------------------------------
// thermistor_ratio_to_temperature_top
// Converts discharge capture counts into thermistor resistance and degrees C.
//
// Input channel (in_valid/in_ready, capture_count): one beat per capture.
// The first nonzero capture after reset becomes the reference count; that
// beat and every later one yield exactly one output beat.
// Output channel (out_valid/out_ready): temperature_c, resistance_ohms,
// is_reference, temperature_valid. With no reference yet and a zero capture
// all fields are zero.
// Config: cfg_wr_en/cfg_wr_data write reference_ohms (reset 1000); write
// only while idle.
// Sequence: a multiply state, COUNT_W+16 restoring divide steps (32 by
// default), a saturate state, up to 7 table probes plus a final pass to close
// the binary search, and a result state; the divide steps and the table probes
// share the subtract/compare unit.
// One capture is in flight at a time; in_ready is high only while idle, so
// a new capture is taken only after the previous result is loaded. A result
// waiting on out_ready does not block the next capture, only its own result load.
// Reset clears the reference count, the output beat and the sequencer.
// ----------------------------------------------------------------------------
module thermistor_ratio_to_temperature_top
  import trt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [OHMS_W-1:0]           cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CAPTURE_W-1:0]        capture_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [TEMP_W-1:0]    temperature_c,
  output logic [OHMS_W-1:0]           resistance_ohms,
  output logic                        is_reference,
  output logic                        temperature_valid
);

  localparam int CNT_W  = (COUNT_WIDTH < CAPTURE_W) ? COUNT_WIDTH : CAPTURE_W;
  localparam int PW     = CNT_W + OHMS_W;
  localparam int STEP_W = $clog2(PW);
  localparam int SW     = (CNT_W + 1 > OHMS_W) ? CNT_W + 1 : OHMS_W;
  localparam int NSRCH  = (TABLE_DEPTH < TABLE_LEN) ? TABLE_DEPTH : TABLE_LEN;
  localparam int SIW    = $clog2(NSRCH + 1);
  localparam int IW     = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SAT  = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]        state;
  logic [OHMS_W-1:0] ref_ohms;
  logic [CNT_W-1:0]  ref_count;
  logic [CNT_W-1:0]  count;
  logic              ref_flag;
  logic              vld_flag;
  logic [PW-1:0]     prod;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [OHMS_W-1:0] ohms;
  logic [SIW-1:0]    lo;
  logic [SIW-1:0]    hi;

  logic [CNT_W-1:0]  cap;
  logic              accept;
  logic              load;
  logic [CNT_W:0]    rem_shift;
  logic [SIW:0]      mid_sum;
  logic [SIW-1:0]    mid;
  logic [SW-1:0]     op_a;
  logic [SW-1:0]     op_b;
  logic [SW:0]       diff;
  logic              ge;
  logic [IW-1:0]     idx;
  logic [15:0]       temp_full;

  assign cap       = capture_count[CNT_W-1:0];
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign load      = (state == ST_FIN) && (!out_valid || out_ready);
  assign rem_shift = {rem, prod[PW-1]};
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[SIW:1];

  // Shared subtract/compare unit: divider step or table probe.
  always_comb begin
    if (state == ST_DIV) begin
      op_a = SW'(rem_shift);
      op_b = SW'(ref_count);
    end else begin
      op_a = SW'(ohms);
      op_b = SW'(RES_TABLE[TAB_IDX_W'(mid)]);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[SW];
  end

  assign idx       = (lo == SIW'(NSRCH)) ? IW'(TABLE_DEPTH) : IW'(lo);
  assign temp_full = 16'(idx) - 16'(TEMP_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ref_ohms  <= OHMS_RESET;
      ref_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ref_ohms <= cfg_wr_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= cap;
            if (ref_count == '0 && cap == '0) begin
              ref_flag <= 1'b0;
              vld_flag <= 1'b0;
              state    <= ST_FIN;
            end else begin
              ref_flag <= (ref_count == '0);
              vld_flag <= 1'b1;
              state    <= ST_MUL;
              if (ref_count == '0) begin
                ref_count <= cap;
              end
            end
          end
        end
        ST_MUL: begin
          prod  <= PW'(count) * PW'(ref_ohms);
          rem   <= '0;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (ge) begin
            rem <= diff[CNT_W-1:0];
          end else begin
            rem <= rem_shift[CNT_W-1:0];
          end
          prod <= {prod[PW-2:0], ge};
          step <= step + 1'b1;
          if (step == STEP_W'(PW - 1)) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          ohms  <= (|prod[PW-1:OHMS_W]) ? RES_MAX : prod[OHMS_W-1:0];
          lo    <= '0;
          hi    <= SIW'(NSRCH);
          state <= ST_SRCH;
        end
        ST_SRCH: begin
          if (lo == hi) begin
            state <= ST_FIN;
          end else if (ge) begin
            hi <= mid;
          end else begin
            lo <= mid + 1'b1;
          end
        end
        ST_FIN: begin
          if (load) begin
            temperature_c     <= vld_flag ? temp_full[TEMP_W-1:0] : '0;
            resistance_ohms   <= vld_flag ? ohms : '0;
            is_reference      <= ref_flag;
            temperature_valid <= vld_flag;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for thermistor_ratio_to_temperature_top. Captures are
// pushed through the valid/ready input with random gaps, and each output beat
// is compared field by field against an in-bench conversion of the same
// capture. The bench covers the startup captures that come before any
// reference, then the reference capture, the table edges and saturation.
// Random phases follow, each with its own reference_ohms value, 0, 1 and
// 65535 among them.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trt_pkg::*;

  localparam int MAX_GAP         = 12;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int TAIL_CYCLES     = 60;
  localparam int STUCK_LIMIT     = 2000;
  localparam int PRINT_LIMIT     = 40;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [OHMS_W-1:0]        ohms;
    logic                     is_ref;
    logic                     valid;
  } reading_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [OHMS_W-1:0]        cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CAPTURE_W-1:0]     capture_count = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TEMP_W-1:0] temperature_c;
  logic [OHMS_W-1:0]        resistance_ohms;
  logic                     is_reference;
  logic                     temperature_valid;

  // bench copy of the block state and its register
  logic [CAPTURE_W-1:0] ref_count = '0;
  logic [OHMS_W-1:0]    ohms_setting = OHMS_RESET;
  logic [CAPTURE_W-1:0] ref_pick = '0;

  logic [CAPTURE_W-1:0] pending_counts[$];
  reading_t             expected_readings[$];

  int mismatches = 0;
  int readings_checked = 0;
  int stuck_cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit no_idle = 1'b0;

  thermistor_ratio_to_temperature_top dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .capture_count     (capture_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_c     (temperature_c),
    .resistance_ohms   (resistance_ohms),
    .is_reference      (is_reference),
    .temperature_valid (temperature_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic reading_t convert_capture(logic [CAPTURE_W-1:0] count);
    reading_t    r;
    logic [31:0] quotient;
    int          idx;
    r = '0;
    if (ref_count == 0 && count != 0) begin
      ref_count = count;
      r.is_ref = 1'b1;
    end
    if (ref_count == 0) return r;
    quotient = (32'(count) * 32'(ohms_setting)) / 32'(ref_count);
    r.ohms = (quotient > 32'(RES_MAX)) ? RES_MAX : quotient[OHMS_W-1:0];
    idx = 0;
    while (idx < TABLE_DEPTH_DEF && !(idx < TABLE_LEN && r.ohms >= RES_TABLE[idx]))
      idx++;
    r.temp = TEMP_W'(idx - TEMP_OFFSET);
    r.valid = 1'b1;
    return r;
  endfunction

  // smallest capture that converts to at least the given resistance
  function automatic logic [CAPTURE_W-1:0] count_for(int unsigned target);
    longint unsigned c;
    if (ohms_setting == 0) return CAPTURE_W'($urandom);
    c = (longint'(target) * ref_pick + ohms_setting - 1) / ohms_setting;
    return (c > 65535) ? 16'hFFFF : CAPTURE_W'(c);
  endfunction

  function automatic logic [CAPTURE_W-1:0] random_capture();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return count_for($urandom_range(60, 5600));
      6: return count_for(RES_TABLE[$urandom_range(0, TABLE_LEN-1)])
                - CAPTURE_W'($urandom_range(0, 1));
      7, 8: return CAPTURE_W'($urandom_range(0, 65535));
      default: return $urandom_range(0, 1) ? 16'hFFFF : CAPTURE_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_counts.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  // capture driver
  always @(posedge clk) begin : drive
    logic v;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      v = in_valid;
      if (in_valid && in_ready) begin
        expected_readings.push_back(convert_capture(capture_count));
        v = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!v && pending_counts.size() != 0) begin
        if (in_gap == 0) begin
          capture_count <= pending_counts.pop_front();
          v = 1'b1;
        end else begin
          in_gap--;
        end
      end
      in_valid <= v;
    end
  end

  // result monitor; stall is counted while a result waits
  always @(posedge clk) begin : watch
    logic     r;
    reading_t e;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      r = out_ready;
      if (out_valid && out_ready) begin
        readings_checked++;
        if (expected_readings.size() == 0) begin
          report_mismatch("result beat with no capture outstanding");
        end else begin
          e = expected_readings.pop_front();
          if (temperature_c !== e.temp)
            report_mismatch($sformatf("temperature_c %0d, expected %0d",
                                      temperature_c, e.temp));
          if (resistance_ohms !== e.ohms)
            report_mismatch($sformatf("resistance_ohms %0d, expected %0d",
                                      resistance_ohms, e.ohms));
          if (is_reference !== e.is_ref)
            report_mismatch($sformatf("is_reference %b, expected %b",
                                      is_reference, e.is_ref));
          if (temperature_valid !== e.valid)
            report_mismatch($sformatf("temperature_valid %b, expected %b",
                                      temperature_valid, e.valid));
        end
        out_stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        r = (out_stall == 0);
      end else if (!r) begin
        if (out_stall == 0) r = 1'b1;
        else if (out_valid) out_stall--;
      end
      out_ready <= r;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_ohms[$];
    int unsigned edge_ohms[$];
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    ref_pick = CAPTURE_W'($urandom_range(100, 5000));
    @(negedge clk);

    // zero captures before a reference, the reference itself, then edges
    pending_counts.push_back('0);
    pending_counts.push_back('0);
    pending_counts.push_back(ref_pick);
    pending_counts.push_back(ref_pick);
    pending_counts.push_back('0);
    pending_counts.push_back(16'hFFFF);
    pending_counts.push_back(16'd1);
    pending_counts.push_back(ref_pick >> 1);
    edge_ohms = '{5258, 4984, 1000, 84, 81};
    foreach (edge_ohms[i]) begin
      pending_counts.push_back(count_for(edge_ohms[i]));
      pending_counts.push_back(count_for(edge_ohms[i]) - 16'd1);
    end
    wait_idle();

    phase_ohms = '{65535, 1, 0, $urandom_range(2, 65534), 1000,
                   $urandom_range(300, 3000), $urandom_range(1, 65535)};
    foreach (phase_ohms[p]) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= OHMS_W'(phase_ohms[p]);
      ohms_setting = OHMS_W'(phase_ohms[p]);
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      @(negedge clk);
      no_idle = (p % 3 == 2);
      repeat (ITEMS_PER_PHASE) pending_counts.push_back(random_capture());
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d readings against reference count %0d", readings_checked, ref_pick);
    $display("reference_ohms went through reset value and %0d written settings, %0d mismatches",
             phase_ohms.size(), mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
